// ===== rtl/core/pst_pkg.sv =====
// shared types and codes for the pair set table
package pst_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int COUNT_W      = 7;
    localparam int PART_W       = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_PRESENT = 2'd1;
    localparam logic [1:0] STAT_ABSENT  = 2'd2;
    localparam logic [1:0] STAT_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [PART_W-1:0] real_part;
        logic signed [PART_W-1:0] imag_part;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } rsp_t;

endpackage

// ===== rtl/core/pair_set_table.sv =====
// pair set table: linear-search set of complex integer pairs
// a request passes through scan (held slots read and compared in order, up to the first hit),
//   resolve, a move step on a delete hit, then the response load
// throughput: one request at a time, the next taken once the response has loaded;
//   an untaken response holds the sequencer in its finish state and req_ready stays low
// reset: rst_n clears count, sequencer and response valid; slots at or above the count are not read
module pair_set_table
#(
    parameter int CAPACITY = pst_pkg::CAPACITY_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  pst_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output pst_pkg::rsp_t rsp
);
    import pst_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KEY_W = 2 * PART_W;

    // sequencer codes
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_RESOLVE = 3'd2;
    localparam logic [2:0] ST_MOVE    = 3'd3;
    localparam logic [2:0] ST_FINISH  = 3'd4;

    // pair storage: one write port, one registered read port
    logic [KEY_W-1:0] pair_store [CAPACITY];

    // control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // request context and scan datapath
    logic [1:0]       op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0] slot_reg, slot_next;
    logic             found_reg, found_next;
    logic [1:0]       status_reg, status_next;
    logic [KEY_W-1:0] rd_data_reg;
    rsp_t             rsp_reg, rsp_next;

    // memory port controls
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [KEY_W-1:0] mem_wr_data;

    // shared compare against the word read in the previous cycle
    logic             hit;
    logic             full;
    logic [IDX_W-1:0] last_idx;

    assign hit      = cmp_vld_reg && (rd_data_reg == key_reg);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign last_idx = IDX_W'(count_reg - CNT_W'(1));

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmp_vld_next   = cmp_vld_reg;
        rsp_valid_next = rsp_valid_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        issue_next     = issue_reg;
        cmp_idx_next   = cmp_idx_reg;
        slot_next      = slot_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = IDX_W'(issue_reg);
        mem_wr_en      = 1'b0;
        mem_wr_addr    = IDX_W'(count_reg);
        mem_wr_data    = key_reg;

        // response register drains independently of the sequencer
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next      = req.opcode;
                    key_next     = {req.imag_part, req.real_part};
                    issue_next   = '0;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // read slot issue_reg while comparing the slot read last cycle
                if (hit)
                begin
                    found_next   = 1'b1;
                    slot_next    = cmp_idx_reg;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_RESOLVE;
                end
                else if (issue_reg < count_reg)
                begin
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = IDX_W'(issue_reg);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = IDX_W'(issue_reg);
                    issue_next   = issue_reg + CNT_W'(1);
                end
                else
                begin
                    // every held slot compared without a match
                    found_next   = 1'b0;
                    cmp_vld_next = 1'b0;
                    state_next   = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                status_next = STAT_DONE;
                state_next  = ST_FINISH;
                unique case (op_reg)
                    OP_INSERT:
                    begin
                        if (found_reg)
                        begin
                            status_next = STAT_PRESENT;
                        end
                        else if (full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            // append after the last held pair
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = IDX_W'(count_reg);
                            mem_wr_data = key_reg;
                            count_next  = count_reg + CNT_W'(1);
                        end
                    end
                    OP_DELETE:
                    begin
                        if (!found_reg)
                        begin
                            status_next = STAT_ABSENT;
                        end
                        else
                        begin
                            // fetch the last pair to fill the freed slot
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = last_idx;
                            count_next  = count_reg - CNT_W'(1);
                            state_next  = ST_MOVE;
                        end
                    end
                    OP_LOOKUP:
                    begin
                    end
                    default:
                    begin
                        // unused opcode behaves as a lookup
                    end
                endcase
            end
            ST_MOVE:
            begin
                // same slot when the last pair was deleted, harmless rewrite
                mem_wr_en   = 1'b1;
                mem_wr_addr = slot_reg;
                mem_wr_data = rd_data_reg;
                state_next  = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status   = status_reg;
                    rsp_next.found    = found_reg;
                    rsp_next.count    = COUNT_W'(count_reg);
                    rsp_next.is_empty = (count_reg == '0);
                    rsp_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_vld_reg   <= cmp_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_reg     <= key_next;
        issue_reg   <= issue_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        rsp_reg     <= rsp_next;
    end

    // pair memory
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            pair_store[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= pair_store[mem_rd_addr];
        end
    end

endmodule

// ===== rtl/core/pst_checker.sv =====
// port-level checks for the pair set table, bound to every pair_set_table instance
module pst_checker
(
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input pst_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input pst_pkg::rsp_t rsp
);
    import pst_pkg::*;

    // a waiting request holds its payload
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_ready) |=> (req_valid && $stable(req)))
        else $error("request changed before it was taken");

    // one request in flight: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while a search was still running");

    // a waiting response holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("response changed before it was taken");

    // status and found flag agree
    a_status_found: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == STAT_PRESENT)) |-> rsp.found)
        else $error("already present reported without a hit");

    a_absent_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && ((rsp.status == STAT_ABSENT) || (rsp.status == STAT_FULL)))
            |-> !rsp.found)
        else $error("miss status reported with a hit");

endmodule

bind pair_set_table pst_checker u_pst_checker (.*);
